>>> src/htfcc_pkg.sv
// ----------------------------------------------------------------------------
// htfcc_pkg
// Shared constants and helpers for the humidity/temperature frame checker:
// byte positions, CRC-8 step, scaling constants and the divide-by-65535.
// ----------------------------------------------------------------------------
package htfcc_pkg;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int TICK_W = 16;
  localparam int TEMP_W = 15;
  localparam int HUM_W  = 14;
  localparam int POS_W  = 3;

  // Byte positions within one six-byte frame
  localparam logic [POS_W-1:0] POS_TEMP_MSB = 3'd0;
  localparam logic [POS_W-1:0] POS_TEMP_LSB = 3'd1;
  localparam logic [POS_W-1:0] POS_TEMP_CRC = 3'd2;
  localparam logic [POS_W-1:0] POS_HUM_MSB  = 3'd3;
  localparam logic [POS_W-1:0] POS_HUM_LSB  = 3'd4;
  localparam logic [POS_W-1:0] POS_HUM_CRC  = 3'd5;

  // CRC-8 settings
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

  // Scaling constants, in hundredths
  localparam logic [31:0]       TEMP_SPAN   = 32'd17500;
  localparam logic [31:0]       HUM_SPAN    = 32'd12500;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
  localparam logic [HUM_W-1:0]  HUM_OFFSET  = 14'd600;
  localparam logic [HUM_W-1:0]  HUM_MAX     = 14'd10000;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN_C = -15'sd4500;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX_C = 15'sd13000;

  // Feed one byte into the CRC-8, msb first
  function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for quotients below 65536: (x + (x >> 16) + 1) >> 16
  function automatic logic [15:0] div_65535(input logic [31:0] x);
    logic [31:0] s;
    s = x + {16'd0, x[31:16]} + 32'd1;
    return s[31:16];
  endfunction

endpackage

>>> src/humidity_temp_frame_check_convert_core.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_check_convert_core
// CRC-checked six-byte sensor frame to temperature and humidity in hundredths.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one response byte per beat, in frame order: temp
//   msb, temp lsb, temp crc, hum msb, hum lsb, hum crc. Each word is checked
//   with CRC-8 (poly 0x31, init 0xFF). The out_ channel carries one result
//   beat per frame, produced by the sixth byte.
//   Timing: a byte is taken into the input register when accepted and processed
//   from there into the frame state; the sixth byte loads the result register,
//   which drives out_valid. One byte per cycle is sustained while the result
//   beat is taken in time; the CRC step and the constant scaling settle in
//   the single stage between the input and result registers.
//   On a CRC error out_crc_error is set and the last good readings are
//   repeated (zero before the first good frame).
//   Reset returns the byte position to the frame start, clears the held
//   readings and empties both registers. There is no resync other than reset.
//   When the receiver stalls, the result register holds; bytes keep flowing
//   until the next frame's sixth byte, which waits in the input register with
//   in_ready low until the result beat is taken.
// ----------------------------------------------------------------------------
module humidity_temp_frame_check_convert_core (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [htfcc_pkg::BYTE_W-1:0]             in_data_byte,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [htfcc_pkg::TEMP_W-1:0]      out_temperature_centi,
  output logic [htfcc_pkg::HUM_W-1:0]              out_humidity_centi,
  output logic                                     out_crc_error
);

  // Input register
  logic                          s1_valid_r;
  logic [htfcc_pkg::BYTE_W-1:0]  s1_byte_r;

  // Frame state
  logic [htfcc_pkg::POS_W-1:0]   pos_r,        pos_nxt;
  logic [htfcc_pkg::BYTE_W-1:0]  crc_r,        crc_nxt;
  logic [htfcc_pkg::TICK_W-1:0]  temp_ticks_r, temp_ticks_nxt;
  logic                          temp_ok_r,    temp_ok_nxt;
  logic [htfcc_pkg::TICK_W-1:0]  hum_ticks_r,  hum_ticks_nxt;
  logic signed [htfcc_pkg::TEMP_W-1:0] held_temp_r, held_temp_nxt;
  logic [htfcc_pkg::HUM_W-1:0]   held_hum_r,   held_hum_nxt;

  // Result register
  logic                          out_valid_r;
  logic signed [htfcc_pkg::TEMP_W-1:0] out_temp_r;
  logic [htfcc_pkg::HUM_W-1:0]   out_hum_r;
  logic                          out_err_r;

  logic [htfcc_pkg::POS_W-1:0]   pos_eff;
  logic                          s1_last;
  logic                          s1_fire;
  logic                          out_free;
  logic [htfcc_pkg::BYTE_W-1:0]  crc_step;
  logic                          hum_ok;
  logic                          frame_ok;
  logic [31:0]                   temp_prod;
  logic [31:0]                   hum_prod;
  logic [15:0]                   temp_q;
  logic [15:0]                   hum_q;
  logic signed [15:0]            temp_full;
  logic [htfcc_pkg::HUM_W-1:0]   hum_conv;

  // Treat a stray position as the start of a new frame
  assign pos_eff = (pos_r > htfcc_pkg::POS_HUM_CRC) ? htfcc_pkg::POS_TEMP_MSB : pos_r;
  assign s1_last = (pos_eff == htfcc_pkg::POS_HUM_CRC);

  // Advance the stage unless a result would overwrite one still waiting
  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && (!s1_last || out_free);
  assign in_ready = !s1_valid_r || s1_fire;

  // CRC step, seeded from init on the first byte of each word
  assign crc_step = htfcc_pkg::crc8_feed(
      ((pos_eff == htfcc_pkg::POS_TEMP_MSB) || (pos_eff == htfcc_pkg::POS_HUM_MSB))
        ? htfcc_pkg::CRC_INIT : crc_r,
      s1_byte_r);

  assign hum_ok   = (s1_byte_r == crc_r);
  assign frame_ok = temp_ok_r && hum_ok;

  // Scale the ticks: span * ticks / 65535, then offset; humidity is also clamped
  assign temp_prod = {16'd0, temp_ticks_r} * htfcc_pkg::TEMP_SPAN;
  assign hum_prod  = {16'd0, hum_ticks_r} * htfcc_pkg::HUM_SPAN;
  assign temp_q    = htfcc_pkg::div_65535(temp_prod);
  assign hum_q     = htfcc_pkg::div_65535(hum_prod);
  assign temp_full = $signed(temp_q) - htfcc_pkg::TEMP_OFFSET;

  always_comb begin
    if (hum_q[htfcc_pkg::HUM_W-1:0] < htfcc_pkg::HUM_OFFSET) begin
      hum_conv = '0;
    end else if ((hum_q[htfcc_pkg::HUM_W-1:0] - htfcc_pkg::HUM_OFFSET) > htfcc_pkg::HUM_MAX) begin
      hum_conv = htfcc_pkg::HUM_MAX;
    end else begin
      hum_conv = hum_q[htfcc_pkg::HUM_W-1:0] - htfcc_pkg::HUM_OFFSET;
    end
  end

  // Next frame state for the byte in the input register
  always_comb begin
    crc_nxt        = crc_r;
    temp_ticks_nxt = temp_ticks_r;
    temp_ok_nxt    = temp_ok_r;
    hum_ticks_nxt  = hum_ticks_r;
    held_temp_nxt  = held_temp_r;
    held_hum_nxt   = held_hum_r;
    pos_nxt        = s1_last ? htfcc_pkg::POS_TEMP_MSB : pos_eff + 3'd1;
    case (pos_eff)
      htfcc_pkg::POS_TEMP_MSB: begin
        crc_nxt        = crc_step;
        temp_ticks_nxt = {s1_byte_r, 8'd0};
      end
      htfcc_pkg::POS_TEMP_LSB: begin
        crc_nxt        = crc_step;
        temp_ticks_nxt = {temp_ticks_r[15:8], s1_byte_r};
      end
      htfcc_pkg::POS_TEMP_CRC: begin
        temp_ok_nxt = (s1_byte_r == crc_r);
        crc_nxt     = htfcc_pkg::CRC_INIT;
      end
      htfcc_pkg::POS_HUM_MSB: begin
        crc_nxt       = crc_step;
        hum_ticks_nxt = {s1_byte_r, 8'd0};
      end
      htfcc_pkg::POS_HUM_LSB: begin
        crc_nxt       = crc_step;
        hum_ticks_nxt = {hum_ticks_r[15:8], s1_byte_r};
      end
      htfcc_pkg::POS_HUM_CRC: begin
        crc_nxt = htfcc_pkg::CRC_INIT;
        if (frame_ok) begin
          held_temp_nxt = temp_full[htfcc_pkg::TEMP_W-1:0];
          held_hum_nxt  = hum_conv;
        end
      end
      default: begin
        crc_nxt = crc_r;
      end
    endcase
  end

  // Hold the incoming byte in the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
    end
  end

  // Update frame state when the stage advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= htfcc_pkg::POS_TEMP_MSB;
      crc_r        <= htfcc_pkg::CRC_INIT;
      temp_ticks_r <= '0;
      temp_ok_r    <= 1'b0;
      hum_ticks_r  <= '0;
      held_temp_r  <= '0;
      held_hum_r   <= '0;
    end else if (s1_fire) begin
      pos_r        <= pos_nxt;
      crc_r        <= crc_nxt;
      temp_ticks_r <= temp_ticks_nxt;
      temp_ok_r    <= temp_ok_nxt;
      hum_ticks_r  <= hum_ticks_nxt;
      held_temp_r  <= held_temp_nxt;
      held_hum_r   <= held_hum_nxt;
    end
  end

  // Load the result beat on the sixth byte; drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_temp_r <= held_temp_nxt;
      out_hum_r  <= held_hum_nxt;
      out_err_r  <= !frame_ok;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = out_temp_r;
  assign out_humidity_centi    = out_hum_r;
  assign out_crc_error         = out_err_r;

endmodule

>>> src/htfcc_checker.sv
// ----------------------------------------------------------------------------
// htfcc_checker
// Port-level checks for the frame checker: result ranges, held readings on
// a CRC error, stall behavior and reset.
// ----------------------------------------------------------------------------
module htfcc_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [htfcc_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [htfcc_pkg::TEMP_W-1:0] out_temperature_centi,
  input  logic [htfcc_pkg::HUM_W-1:0]         out_humidity_centi,
  input  logic                                out_crc_error
);

  // Track the readings of the last delivered result beat
  logic signed [htfcc_pkg::TEMP_W-1:0] last_temp_r;
  logic [htfcc_pkg::HUM_W-1:0]         last_hum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_temp_r <= '0;
      last_hum_r  <= '0;
    end else if (out_valid && out_ready) begin
      last_temp_r <= out_temperature_centi;
      last_hum_r  <= out_humidity_centi;
    end
  end

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_temperature_centi)
        && $stable(out_humidity_centi) && $stable(out_crc_error))
    else $error("result beat changed while stalled");

  // Keep readings in their ranges
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> (out_humidity_centi <= htfcc_pkg::HUM_MAX)
        && (out_temperature_centi >= htfcc_pkg::TEMP_MIN_C)
        && (out_temperature_centi <= htfcc_pkg::TEMP_MAX_C))
    else $error("reading out of range");

  // Repeat the last good readings on a CRC error
  a_err_holds: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_crc_error |-> (out_temperature_centi == last_temp_r)
        && (out_humidity_centi == last_hum_r))
    else $error("readings changed on a CRC error");

  // Empty the result register at reset
  a_reset: assert property (@(posedge clk)
      !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // Hold a waiting input beat until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && !in_ready |=> in_valid && $stable(in_data_byte))
    else $error("input beat changed while waiting");

endmodule

bind humidity_temp_frame_check_convert_core htfcc_checker u_htfcc_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .in_data_byte          (in_data_byte),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_temperature_centi (out_temperature_centi),
  .out_humidity_centi    (out_humidity_centi),
  .out_crc_error         (out_crc_error)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the checked humidity/temperature frame converter.
// Feeds six-byte sensor frames (good, CRC-corrupted and noise) through the
// in_ channel under random idling, predicts each per-frame reading with an
// independent CRC-8 and scaling model, and checks every out_ beat in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          CLK_HALF       = 5;
  localparam int          RESET_CYCLES   = 7;
  localparam int          RANDOM_FRAMES  = 88;
  localparam int          CALM_TAIL      = 60;
  localparam int          HOLD_AFTER     = 30;
  localparam int          HOLD_CYCLES    = 48;
  localparam int          DRAIN_CYCLES   = 10;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam logic [31:0] TICK_FULL      = 32'd65535;

  typedef logic [htfcc_pkg::BYTE_W-1:0] byte_t;
  typedef logic [htfcc_pkg::TICK_W-1:0] tick_t;
  typedef logic [htfcc_pkg::POS_W-1:0]  pos_t;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_TEMP,
    FRAME_BAD_HUM,
    FRAME_BAD_BOTH,
    FRAME_NOISE
  } frame_kind_t;

  typedef struct {
    logic signed [htfcc_pkg::TEMP_W-1:0] temperature;
    logic [htfcc_pkg::HUM_W-1:0]         humidity;
    logic                                crc_error;
  } reading_t;

  // DUT ports; the bench-driven inputs are known from time zero
  logic                                clk          = 1'b0;
  logic                                rst_n        = 1'b0;
  logic                                in_valid     = 1'b0;
  logic                                in_ready;
  byte_t                               in_data_byte = '0;
  logic                                out_valid;
  logic                                out_ready    = 1'b0;
  logic signed [htfcc_pkg::TEMP_W-1:0] out_temperature_centi;
  logic [htfcc_pkg::HUM_W-1:0]         out_humidity_centi;
  logic                                out_crc_error;

  // Stimulus and expectations
  byte_t    byte_queue[$];
  reading_t expected_readings[$];

  // Predictor state
  pos_t                                frame_pos;
  byte_t                               crc_acc;
  tick_t                               temp_raw;
  logic                                temp_good;
  tick_t                               hum_raw;
  logic signed [htfcc_pkg::TEMP_W-1:0] last_temp;
  logic [htfcc_pkg::HUM_W-1:0]         last_hum;

  // Bookkeeping
  int   error_count   = 0;
  int   bytes_taken   = 0;
  int   results_seen  = 0;
  int   crc_err_seen  = 0;
  int   idle_cycles   = 0;
  logic in_beat_taken = 1'b0;
  int   in_gap        = 0;
  int   out_gap       = 0;
  int   hold_left     = 0;
  bit   hold_done     = 1'b0;

  humidity_temp_frame_check_convert_core u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_byte          (in_data_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_crc_error         (out_crc_error)
  );

  always #CLK_HALF clk = ~clk;

  // Bitwise CRC-8, one data bit per shift, msb first
  function automatic byte_t crc_over(input byte_t seed, input byte_t d);
    byte_t c;
    logic  fb;
    c = seed;
    for (int i = htfcc_pkg::BYTE_W - 1; i >= 0; i--) begin
      fb = c[htfcc_pkg::BYTE_W-1] ^ d[i];
      c  = {c[htfcc_pkg::BYTE_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ htfcc_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic byte_t word_crc(input tick_t w);
    return crc_over(crc_over(htfcc_pkg::CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Advance the frame model by one accepted byte; queue a reading on the sixth
  task automatic absorb_byte(input byte_t b);
    pos_t     pos;
    int       t_scaled;
    int       h_scaled;
    reading_t r;
    pos = (frame_pos > htfcc_pkg::POS_HUM_CRC) ? htfcc_pkg::POS_TEMP_MSB : frame_pos;
    case (pos)
      htfcc_pkg::POS_TEMP_MSB: begin
        crc_acc  = crc_over(htfcc_pkg::CRC_INIT, b);
        temp_raw = {b, 8'h00};
      end
      htfcc_pkg::POS_TEMP_LSB: begin
        crc_acc  = crc_over(crc_acc, b);
        temp_raw = {temp_raw[15:8], b};
      end
      htfcc_pkg::POS_TEMP_CRC: begin
        temp_good = (b == crc_acc);
        crc_acc   = htfcc_pkg::CRC_INIT;
      end
      htfcc_pkg::POS_HUM_MSB: begin
        crc_acc = crc_over(htfcc_pkg::CRC_INIT, b);
        hum_raw = {b, 8'h00};
      end
      htfcc_pkg::POS_HUM_LSB: begin
        crc_acc = crc_over(crc_acc, b);
        hum_raw = {hum_raw[15:8], b};
      end
      default: begin
        r.crc_error = !(temp_good && (b == crc_acc));
        crc_acc     = htfcc_pkg::CRC_INIT;
        if (!r.crc_error) begin
          t_scaled = int'((32'(temp_raw) * htfcc_pkg::TEMP_SPAN) / TICK_FULL)
                     - int'(htfcc_pkg::TEMP_OFFSET);
          h_scaled = int'((32'(hum_raw) * htfcc_pkg::HUM_SPAN) / TICK_FULL)
                     - int'(htfcc_pkg::HUM_OFFSET);
          if (h_scaled < 0) begin
            h_scaled = 0;
          end
          if (h_scaled > int'(htfcc_pkg::HUM_MAX)) begin
            h_scaled = int'(htfcc_pkg::HUM_MAX);
          end
          last_temp = t_scaled[htfcc_pkg::TEMP_W-1:0];
          last_hum  = h_scaled[htfcc_pkg::HUM_W-1:0];
        end
        r.temperature = last_temp;
        r.humidity    = last_hum;
        expected_readings.push_back(r);
      end
    endcase
    frame_pos = (pos >= htfcc_pkg::POS_HUM_CRC) ? htfcc_pkg::POS_TEMP_MSB : pos + 1'b1;
  endtask

  // Queue one six-byte frame, corrupting CRC bytes as the kind asks
  task automatic push_frame(input frame_kind_t kind, input tick_t t, input tick_t h);
    byte_t t_crc;
    byte_t h_crc;
    t_crc = word_crc(t);
    h_crc = word_crc(h);
    if (kind == FRAME_BAD_TEMP || kind == FRAME_BAD_BOTH) begin
      t_crc = t_crc ^ byte_t'($urandom_range(1, 255));
    end
    if (kind == FRAME_BAD_HUM || kind == FRAME_BAD_BOTH) begin
      h_crc = h_crc ^ byte_t'($urandom_range(1, 255));
    end
    if (kind == FRAME_NOISE) begin
      repeat (6) byte_queue.push_back(byte_t'($urandom_range(0, 255)));
    end else begin
      byte_queue.push_back(t[15:8]);
      byte_queue.push_back(t[7:0]);
      byte_queue.push_back(t_crc);
      byte_queue.push_back(h[15:8]);
      byte_queue.push_back(h[7:0]);
      byte_queue.push_back(h_crc);
    end
  endtask

  // Ticks biased toward the ends of the range and the humidity clamp points
  function automatic tick_t pick_ticks();
    case ($urandom_range(0, 9))
      0:       return tick_t'($urandom_range(0, 3));
      1:       return tick_t'($urandom_range(16'hFFFC, 16'hFFFF));
      2:       return tick_t'($urandom_range(3140, 3150));
      3:       return tick_t'($urandom_range(55570, 55580));
      default: return tick_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) begin
      return FRAME_GOOD;
    end else if (r == 15) begin
      return FRAME_BAD_TEMP;
    end else if (r == 16) begin
      return FRAME_BAD_HUM;
    end else if (r == 17) begin
      return FRAME_BAD_BOTH;
    end
    return FRAME_NOISE;
  endfunction

  // Stimulus, reset and end of run
  initial begin
    frame_pos = htfcc_pkg::POS_TEMP_MSB;
    crc_acc   = htfcc_pkg::CRC_INIT;
    temp_raw  = '0;
    temp_good = 1'b0;
    hum_raw   = '0;
    last_temp = '0;
    last_hum  = '0;

    // Error before any good frame, then both clamp extremes and a humidity error
    push_frame(FRAME_BAD_TEMP, 16'hFFFF, 16'h0000);
    push_frame(FRAME_GOOD,     16'h0000, 16'h0000);
    push_frame(FRAME_BAD_HUM,  16'h1234, 16'h8000);
    push_frame(FRAME_GOOD,     16'hFFFF, 16'hFFFF);

    for (int i = 0; i < RANDOM_FRAMES; i++) begin
      push_frame(pick_kind(), pick_ticks(), pick_ticks());
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bytes, %0d frame results, %0d of them flagged as CRC errors.",
             bytes_taken, results_seen, crc_err_seen);
    $display("Includes clamp extremes, error before first good frame and a long out_ hold.");
    if (error_count == 0 && expected_readings.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Note an input beat at the edge it is taken; feed the predictor
  always @(posedge clk) begin
    in_beat_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      absorb_byte(in_data_byte);
      bytes_taken++;
    end
  end

  // Input driver: hold until taken, idle in short bursts, calm at the tail
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_beat_taken) begin
      // hold the pending beat
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap   = in_gap - 1;
    end else if (byte_queue.size() > CALM_TAIL && ((bytes_taken / 48) % 3 != 2)
                 && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      in_gap   = $urandom_range(0, 2);
    end else if (byte_queue.size() != 0) begin
      in_valid     <= 1'b1;
      in_data_byte <= byte_queue.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver: one long hold-off, short stall bursts, calm at the tail
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      out_ready <= 1'b0;
      hold_left = HOLD_CYCLES - 1;
      hold_done = 1'b1;
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap   = out_gap - 1;
    end else if (byte_queue.size() > CALM_TAIL && ((results_seen / 8) % 3 != 1)
                 && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      out_gap   = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest predicted reading
  always @(posedge clk) begin : check_results
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_crc_error) begin
        crc_err_seen++;
      end
      if (expected_readings.size() == 0) begin
        $error("unexpected result beat: temperature_centi %0d, humidity_centi %0d",
               out_temperature_centi, out_humidity_centi);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        if (out_temperature_centi !== want.temperature) begin
          $error("temperature_centi mismatch: expected %0d, actual %0d",
                 want.temperature, out_temperature_centi);
          error_count++;
        end
        if (out_humidity_centi !== want.humidity) begin
          $error("humidity_centi mismatch: expected %0d, actual %0d",
                 want.humidity, out_humidity_centi);
          error_count++;
        end
        if (out_crc_error !== want.crc_error) begin
          $error("crc_error mismatch: expected %0b, actual %0b",
                 want.crc_error, out_crc_error);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles.", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> filelist.f
src/htfcc_pkg.sv
src/humidity_temp_frame_check_convert_core.sv
src/htfcc_checker.sv
tb/testbench.sv
